// File: rtl/core/mtg_pkg.sv
// ============================================================================
// mtg_pkg
// Shared constants, types and functions of the MT19937 generator.
// ============================================================================
package mtg_pkg;

    localparam int STATE_WORDS   = 624;
    localparam int MIDDLE_OFFSET = 397;
    localparam int WORD_W        = 32;
    localparam int ADDR_W        = $clog2(STATE_WORDS);
    localparam int PTR_W         = $clog2(STATE_WORDS + 2);

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
    localparam logic [WORD_W-1:0] HALF_HIGH    = 32'hffff_0000;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef struct packed {
        logic              seed_load;
        logic              seed_default;
        logic              seed_hi;
        logic              seed_lo;
        logic              ram_re;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              cap_y;
        logic              twist_wr;
        logic [ADDR_W-1:0] wr_addr;
        logic              out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] p;
        p = s * LCG_MULT;
        return p + 32'd1;
    endfunction

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// File: rtl/core/mtg_ram.sv
// ============================================================================
// mtg_ram
// Generic RAM: one write port, two read ports with registered read data.
// ============================================================================
module mtg_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 624,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: rtl/core/mtg_ctrl.sv
// ============================================================================
// mtg_ctrl
// Sequencer: seeding sweep, in-place twist sweep and draw handshake.
// ============================================================================
module mtg_ctrl #(
    parameter int DEPTH      = mtg_pkg::STATE_WORDS,
    parameter int MID_OFFSET = mtg_pkg::MIDDLE_OFFSET
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    output mtg_pkg::t_dp_cmd     o_cmd,
    input  mtg_pkg::t_dp_sts     i_sts
);

    localparam int AW = mtg_pkg::ADDR_W;
    localparam int PW = mtg_pkg::PTR_W;
    localparam logic [PW-1:0] POS_END   = PW'(DEPTH);
    localparam logic [PW-1:0] POS_NEVER = PW'(DEPTH + 1);
    localparam logic [AW-1:0] K_LAST    = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEED_HI,
        S_SEED_LO,
        S_TW_RD1,
        S_TW_RD2,
        S_TW_WR,
        S_DRAW_RD,
        S_DRAW_OUT
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_k, n_k;
    logic            r_after, n_after;

    logic [AW-1:0]   k_nxt;
    logic [AW:0]     mid_sum;
    logic [AW-1:0]   k_mid;
    logic            accept;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign k_nxt    = (r_k == K_LAST) ? '0 : r_k + AW'(1);
    assign mid_sum  = {1'b0, r_k} + (AW+1)'(MID_OFFSET);
    assign k_mid    = (mid_sum >= (AW+1)'(DEPTH)) ? AW'(mid_sum - (AW+1)'(DEPTH))
                                                  : mid_sum[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_k     = r_k;
        n_after = r_after;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_k = '0;
                    if (i_operation == mtg_pkg::OP_SEED) begin
                        o_cmd.seed_load = 1'b1;
                        n_after = 1'b0;
                        n_state = S_SEED_HI;
                    end else if (r_pos == POS_NEVER) begin
                        o_cmd.seed_load    = 1'b1;
                        o_cmd.seed_default = 1'b1;
                        n_after = 1'b1;
                        n_state = S_SEED_HI;
                    end else if (r_pos == POS_END) begin
                        n_state = S_TW_RD1;
                    end else begin
                        n_state = S_DRAW_RD;
                    end
                end
            end
            S_SEED_HI: begin
                o_cmd.seed_hi = 1'b1;
                n_state = S_SEED_LO;
            end
            S_SEED_LO: begin
                o_cmd.seed_lo = 1'b1;
                o_cmd.wr_addr = r_k;
                n_k = k_nxt;
                if (r_k == K_LAST) begin
                    n_pos   = POS_END;
                    n_state = r_after ? S_TW_RD1 : S_IDLE;
                end else begin
                    n_state = S_SEED_HI;
                end
            end
            S_TW_RD1: begin
                o_cmd.ram_re    = 1'b1;
                o_cmd.rd_addr_a = r_k;
                o_cmd.rd_addr_b = k_nxt;
                n_state = S_TW_RD2;
            end
            S_TW_RD2: begin
                o_cmd.ram_re    = 1'b1;
                o_cmd.rd_addr_a = k_mid;
                o_cmd.rd_addr_b = k_mid;
                o_cmd.cap_y     = 1'b1;
                n_state = S_TW_WR;
            end
            S_TW_WR: begin
                o_cmd.twist_wr = 1'b1;
                o_cmd.wr_addr  = r_k;
                n_k = k_nxt;
                if (r_k == K_LAST) begin
                    n_pos   = '0;
                    n_state = S_DRAW_RD;
                end else begin
                    n_state = S_TW_RD1;
                end
            end
            S_DRAW_RD: begin
                o_cmd.ram_re    = 1'b1;
                o_cmd.rd_addr_a = r_pos[AW-1:0];
                o_cmd.rd_addr_b = r_pos[AW-1:0];
                n_pos   = r_pos + PW'(1);
                n_state = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= POS_NEVER;
            r_k     <= '0;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_k     <= n_k;
            r_after <= n_after;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/mtg_dp.sv
// ============================================================================
// mtg_dp
// Datapath: state RAM, seeding LCG, twist word, tempering and output word.
// ============================================================================
module mtg_dp #(
    parameter int DEPTH = mtg_pkg::STATE_WORDS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mtg_pkg::t_dp_cmd            i_cmd,
    output mtg_pkg::t_dp_sts            o_sts,
    input  logic [mtg_pkg::WORD_W-1:0]  i_seed_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mtg_pkg::WORD_W-1:0]  o_random_word
);

    localparam int W = mtg_pkg::WORD_W;

    logic [W-1:0] r_seed;
    logic [W-1:0] r_hi;
    logic [W-1:0] r_y;
    logic [W-1:0] r_out;
    logic         r_out_valid;

    logic [W-1:0] rd_a;
    logic [W-1:0] rd_b;
    logic [W-1:0] seed_step;
    logic [W-1:0] twist_word;
    logic [W-1:0] wdata;
    logic         we;

    assign seed_step  = mtg_pkg::lcg_next(r_seed);
    assign twist_word = rd_a ^ (r_y >> 1) ^ (r_y[0] ? mtg_pkg::TWIST_MATRIX : '0);
    assign we         = i_cmd.seed_lo || i_cmd.twist_wr;
    assign wdata      = i_cmd.seed_lo ? (r_hi | {16'h0000, r_seed[W-1:16]}) : twist_word;

    mtg_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (i_cmd.wr_addr),
        .i_wdata   (wdata),
        .i_re      (i_cmd.ram_re),
        .i_raddr_a (i_cmd.rd_addr_a),
        .i_raddr_b (i_cmd.rd_addr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed_load) begin
            r_seed <= i_cmd.seed_default ? mtg_pkg::DEFAULT_SEED : i_seed_value;
        end else if (i_cmd.seed_hi || i_cmd.seed_lo) begin
            r_seed <= seed_step;
        end
        if (i_cmd.seed_hi) begin
            r_hi <= r_seed & mtg_pkg::HALF_HIGH;
        end
        if (i_cmd.cap_y) begin
            r_y <= (rd_a & mtg_pkg::HIGH_BIT) | (rd_b & mtg_pkg::LOW_BITS);
        end
        if (i_cmd.out_load) begin
            r_out <= mtg_pkg::temper(rd_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_random_word  = r_out;

endmodule

// File: rtl/core/mersenne_twister_generator_top.sv
// ============================================================================
// mersenne_twister_generator_top
// MT19937 generator: 624-word state in RAM, tempered 32-bit output words.
// ============================================================================
// Input channel (i_in_valid / o_in_ready) carries one word: i_operation and
// i_seed_value. Operation draw returns one tempered word on the output
// channel (o_out_valid / i_out_ready); operation seed returns nothing.
// Input is taken only while the sequencer is idle.
// A draw from a twisted state reads its word, then loads the tempered word
// once the output register is free; o_out_valid rises and the input is
// ready again in the same cycle. Every 624th draw, and the first draw after
// a seed, first twists the state in place, word by word (RAM read of word k
// and k+1, then word k+397, then write of word k).
// A seed fills the state word by word, high half then low half (one LCG
// multiply per cycle). A draw with no seed since reset first seeds with
// 4357, then twists.
// Reset clears the sequencer and the output valid; the RAM is not cleared,
// it is always written before it is read.
// When the receiver stalls, the output word holds; input is still taken
// until a draw waits for the output register, then o_in_ready stays low.
// ============================================================================
module mersenne_twister_generator_top #(
    parameter int STATE_WORDS   = mtg_pkg::STATE_WORDS,
    parameter int MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [mtg_pkg::WORD_W-1:0]  i_seed_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mtg_pkg::WORD_W-1:0]  o_random_word
);

    mtg_pkg::t_dp_cmd cmd;
    mtg_pkg::t_dp_sts sts;

    mtg_ctrl #(
        .DEPTH      (STATE_WORDS),
        .MID_OFFSET (MIDDLE_OFFSET)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mtg_dp #(
        .DEPTH (STATE_WORDS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_seed_value  (i_seed_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_random_word (o_random_word)
    );

    a_reset_no_word: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    a_seed_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_operation == mtg_pkg::OP_SEED && !o_out_valid)
        |=> !o_out_valid)
        else $error("seed produced an output word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again while item in progress");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("output word overwritten before taken");

endmodule

// File: tb/mersenne_twister_generator_top_tb.sv
// ============================================================================
// mersenne_twister_generator_top_tb
// Self-checking bench for the MT19937 generator. A queue of draw and seed
// words feeds a valid/ready driver; a bit-accurate software generator
// predicts every tempered word, and the monitor compares each word taken
// off the output channel against the oldest prediction. Both sides insert
// random gaps. One long receiver stall and three sender drains are included.
// ============================================================================
module mersenne_twister_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                        WORD_W        = mtg_pkg::WORD_W;
    localparam int                        STATE_WORDS   = mtg_pkg::STATE_WORDS;
    localparam int                        MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET;
    localparam logic                      OP_DRAW       = mtg_pkg::OP_DRAW;
    localparam logic                      OP_SEED       = mtg_pkg::OP_SEED;
    localparam logic [mtg_pkg::WORD_W-1:0] LCG_MULT     = mtg_pkg::LCG_MULT;
    localparam logic [mtg_pkg::WORD_W-1:0] TWIST_MATRIX = mtg_pkg::TWIST_MATRIX;
    localparam logic [mtg_pkg::WORD_W-1:0] TEMPER_B     = mtg_pkg::TEMPER_B;
    localparam logic [mtg_pkg::WORD_W-1:0] TEMPER_C     = mtg_pkg::TEMPER_C;
    localparam logic [mtg_pkg::WORD_W-1:0] DEFAULT_SEED = mtg_pkg::DEFAULT_SEED;

    typedef struct packed {
        logic              drain;
        logic              op;
        logic [WORD_W-1:0] seed_value;
    } t_gen_item;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_operation = OP_DRAW;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [WORD_W-1:0] o_random_word;

    t_gen_item         pending[$];
    logic [WORD_W-1:0] expected_words[$];
    logic [WORD_W-1:0] mt_state[STATE_WORDS];
    int unsigned       mt_pos = STATE_WORDS + 1;

    int                in_offered = 0;
    int                in_accepts = 0;
    int                words_received = 0;
    int                seen_words = 0;
    int                send_gap = 0;
    int                recv_wait = 0;
    int                recv_hold;
    int                errors = 0;
    logic              no_gaps = 1'b0;
    logic              long_stall = 1'b0;
    t_gen_item         next_item;
    logic [WORD_W-1:0] drawn;
    logic [WORD_W-1:0] want;

    mersenne_twister_generator_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_seed_value (i_seed_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_random_word(o_random_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---- generator model ----
    task automatic load_state(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] s;
        s = seed;
        for (int i = 0; i < STATE_WORDS; i++) begin
            mt_state[i][31:16] = s[31:16];
            s = s * LCG_MULT + 32'd1;
            mt_state[i][15:0] = s[31:16];
            s = s * LCG_MULT + 32'd1;
        end
        mt_pos = STATE_WORDS;
    endtask

    task automatic regenerate_state();
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] v;
        for (int k = 0; k < STATE_WORDS; k++) begin
            y = {mt_state[k][31], mt_state[(k + 1) % STATE_WORDS][30:0]};
            v = mt_state[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ {1'b0, y[31:1]};
            if (y[0])
                v = v ^ TWIST_MATRIX;
            mt_state[k] = v;
        end
        mt_pos = 0;
    endtask

    function automatic logic [WORD_W-1:0] tempered(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ {11'd0, w[31:11]};
        t = t ^ ({t[24:0], 7'd0} & TEMPER_B);
        t = t ^ ({t[16:0], 15'd0} & TEMPER_C);
        return t ^ {18'd0, t[31:18]};
    endfunction

    task automatic draw_word(output logic [WORD_W-1:0] w);
        if (mt_pos >= STATE_WORDS) begin
            if (mt_pos != STATE_WORDS)
                load_state(DEFAULT_SEED);
            regenerate_state();
        end
        w = tempered(mt_state[mt_pos]);
        mt_pos++;
    endtask

    task automatic push_item(input logic op, input logic [WORD_W-1:0] seed,
                             input logic drain);
        t_gen_item it;
        it.drain      = drain;
        it.op         = op;
        it.seed_value = seed;
        pending.push_back(it);
    endtask

    // ---- input driver ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && in_offered != in_accepts) begin
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (pending.size() == 0 ||
                     (pending[0].drain && expected_words.size() != 0)) begin
            i_in_valid <= 1'b0;
        end else begin
            next_item    = pending.pop_front();
            i_in_valid   <= 1'b1;
            i_operation  <= next_item.op;
            i_seed_value <= next_item.seed_value;
            in_offered   <= in_offered + 1;
            send_gap     <= no_gaps ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0)
                no_gaps <= !no_gaps;
        end
    end

    // ---- output receiver ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (seen_words != words_received) begin
            recv_hold = no_gaps ? 0 : $urandom_range(0, 5);
            seen_words  <= words_received;
            recv_wait   <= recv_hold;
            i_out_ready <= (recv_hold == 0) && !long_stall;
        end else if (recv_wait > 0) begin
            recv_wait   <= recv_wait - 1;
            i_out_ready <= (recv_wait == 1) && !long_stall;
        end else begin
            i_out_ready <= !long_stall;
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_accepts <= in_accepts + 1;
                if (i_operation == OP_SEED) begin
                    load_state(i_seed_value);
                end else begin
                    draw_word(drawn);
                    expected_words.push_back(drawn);
                end
            end
            if (o_out_valid && i_out_ready) begin
                words_received <= words_received + 1;
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected random_word, expected none, got %08h",
                             $time, o_random_word);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (o_random_word !== want) begin
                        $display("%0t: random_word expected %08h got %08h",
                                 $time, want, o_random_word);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver holds off long enough for the input side to back up
    initial begin
        wait (in_accepts >= 120);
        @(posedge i_clk);
        long_stall <= 1'b1;
        repeat (600) @(posedge i_clk);
        long_stall <= 1'b0;
    end

    initial begin
        #100_000_000;
        $display("mersenne_twister_generator_top_tb failed");
        $finish;
    end

    initial begin
        // draw before any seed, then seeds at the extremes and back to back
        push_item(OP_DRAW, 32'hffff_ffff, 1'b0);
        push_item(OP_DRAW, 32'h0000_0000, 1'b0);
        push_item(OP_SEED, 32'h0000_0000, 1'b0);
        push_item(OP_DRAW, 32'h0000_0000, 1'b0);
        push_item(OP_DRAW, 32'hffff_ffff, 1'b0);
        push_item(OP_SEED, 32'hffff_ffff, 1'b0);
        push_item(OP_DRAW, 32'h5555_5555, 1'b0);
        push_item(OP_SEED, 32'haaaa_aaaa, 1'b0);
        push_item(OP_SEED, 32'h5555_5555, 1'b0);
        push_item(OP_DRAW, 32'haaaa_aaaa, 1'b0);
        push_item(OP_SEED, 32'h0000_0001, 1'b1);
        push_item(OP_DRAW, 32'hdead_beef, 1'b0);
        push_item(OP_DRAW, 32'h1234_5678, 1'b0);
        push_item(OP_SEED, DEFAULT_SEED, 1'b0);
        push_item(OP_DRAW, 32'h0000_0000, 1'b0);
        push_item(OP_SEED, 32'h8000_0000, 1'b0);
        push_item(OP_DRAW, 32'h7fff_ffff, 1'b1);
        for (int i = 0; i < 383; i++) begin
            push_item(($urandom_range(0, 24) == 0) ? OP_SEED : OP_DRAW, $urandom(),
                      i == 300);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending.size() == 0 && in_offered == in_accepts);
        wait (expected_words.size() == 0);
        // a trailing seed can still be running
        repeat (3200) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("mersenne_twister_generator_top_tb passed");
        else
            $display("mersenne_twister_generator_top_tb failed");
        $finish;
    end

endmodule
